// ----- hw/rtl/crsfdec_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and the CRC-8 step for the CRSF channel decoder.
// No dependencies; every other file of the decoder imports this package.
package crsfdec_pkg;

    localparam int MAX_FRAME_LENGTH = 62;
    localparam int MIN_FRAME_LENGTH = 2;
    localparam int CHANNEL_COUNT    = 16;
    localparam int PAYLOAD_DEPTH    = 22;
    localparam int PAYLOAD_BITS     = PAYLOAD_DEPTH * 8;
    localparam int PAYLOAD_IDX_W    = $clog2(PAYLOAD_DEPTH);
    localparam int QUEUE_DEPTH      = 2;

    localparam int BYTE_W     = 8;
    localparam int POS_W      = 6;
    localparam int CH_IDX_W   = 4;
    localparam int CH_VALUE_W = 11;
    localparam int STATUS_W   = 2;
    localparam int TDATA_OUT_W = ((CH_IDX_W + CH_VALUE_W + 7) / 8) * 8;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_ADDRESS   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_LENGTH = 1'd1;

    localparam logic [7:0]       SYNC_ADDRESS_RESET = 8'hC8;
    localparam logic [POS_W-1:0] CHAN_LENGTH_RESET  = 6'd24;
    localparam logic [7:0]       CRC_POLY           = 8'hD5;

    // Byte position codes; two and up count bytes taken so far
    localparam logic [POS_W-1:0] POS_HUNT          = 6'd0;
    localparam logic [POS_W-1:0] POS_LENGTH        = 6'd1;
    localparam logic [POS_W-1:0] POS_TYPE          = 6'd2;
    localparam logic [POS_W-1:0] POS_FIRST_PAYLOAD = 6'd3;

    typedef enum logic [STATUS_W-1:0] {
        ST_CHANNELS_OK  = 2'd0,
        ST_CRC_MISMATCH = 2'd1,
        ST_OTHER_LENGTH = 2'd2
    } t_status;

    typedef enum logic {
        BK_IDLE = 1'b0,
        BK_EMIT = 1'b1
    } t_back_state;

    // One finished frame handed from front to back
    typedef struct packed {
        t_status                 status;
        logic [PAYLOAD_BITS-1:0] payload;
    } t_desc;

    function automatic logic [7:0] crc8_update(input logic [7:0] crc,
                                               input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int i = 0; i < 8; i++) begin
            c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

// ----- hw/rtl/crsfdec_front.sv -----
`timescale 1ns / 1ps
// Front end: frame sync hunt, length check, CRC-8 and payload store.
// Pushes one descriptor per completed frame. Depends on crsfdec_pkg.
module crsfdec_front import crsfdec_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_byte_valid,
    input  logic [BYTE_W-1:0]     i_byte,
    output logic                  o_byte_ready,
    output logic                  o_push_valid,
    output t_desc                 o_push_desc,
    input  logic                  i_push_ready
);

    logic [7:0]       r_sync_addr, n_sync_addr;
    logic [POS_W-1:0] r_chan_len, n_chan_len;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [POS_W-1:0] r_len, n_len;
    logic [7:0]       r_crc, n_crc;
    logic [7:0]       r_store [PAYLOAD_DEPTH];

    logic                     accept;
    logic                     store_we;
    logic [PAYLOAD_IDX_W-1:0] store_idx;
    logic [PAYLOAD_BITS-1:0]  payload;
    t_status                  status;

    // Only the CRC byte pushes, so stall input whenever the queue is full
    assign o_byte_ready = i_push_ready;
    assign accept       = i_byte_valid && o_byte_ready;
    assign store_idx    = PAYLOAD_IDX_W'(r_pos - POS_FIRST_PAYLOAD);

    always_comb begin
        for (int i = 0; i < PAYLOAD_DEPTH; i++) begin
            payload[i*8 +: 8] = r_store[i];
        end
    end

    always_comb begin
        n_sync_addr  = r_sync_addr;
        n_chan_len   = r_chan_len;
        n_pos        = r_pos;
        n_len        = r_len;
        n_crc        = r_crc;
        store_we     = 1'b0;
        o_push_valid = 1'b0;
        status       = ST_CHANNELS_OK;

        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SYNC_ADDRESS:   n_sync_addr = i_cfg_data[7:0];
                CFG_CHANNEL_LENGTH: n_chan_len  = i_cfg_data[POS_W-1:0];
                default: ;
            endcase
        end

        if (accept) begin
            case (r_pos)
                POS_HUNT: begin
                    if (i_byte == r_sync_addr) n_pos = POS_LENGTH;
                end
                POS_LENGTH: begin
                    if (i_byte < 8'(MIN_FRAME_LENGTH) || i_byte > 8'(MAX_FRAME_LENGTH)) begin
                        n_pos = POS_HUNT;
                    end else begin
                        n_len = i_byte[POS_W-1:0];
                        n_crc = 8'd0;
                        n_pos = POS_TYPE;
                    end
                end
                default: begin
                    if (r_pos <= r_len) begin
                        n_crc = crc8_update(r_crc, i_byte);
                        // payload bytes past the store end only feed the CRC
                        store_we = (r_pos >= POS_FIRST_PAYLOAD) &&
                                   (r_pos < POS_FIRST_PAYLOAD + POS_W'(PAYLOAD_DEPTH));
                        n_pos = r_pos + 6'd1;
                    end else begin
                        n_pos        = POS_HUNT;
                        o_push_valid = 1'b1;
                        if (i_byte != r_crc) begin
                            status = ST_CRC_MISMATCH;
                        end else if (r_len != r_chan_len) begin
                            status = ST_OTHER_LENGTH;
                        end
                    end
                end
            endcase
        end
    end

    assign o_push_desc.status  = status;
    assign o_push_desc.payload = payload;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_addr <= SYNC_ADDRESS_RESET;
            r_chan_len  <= CHAN_LENGTH_RESET;
            r_pos       <= POS_HUNT;
            r_len       <= '0;
            r_crc       <= '0;
        end else begin
            r_sync_addr <= n_sync_addr;
            r_chan_len  <= n_chan_len;
            r_pos       <= n_pos;
            r_len       <= n_len;
            r_crc       <= n_crc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (store_we) r_store[store_idx] <= i_byte;
    end

endmodule

// ----- hw/rtl/crsfdec_queue.sv -----
`timescale 1ns / 1ps
// Short frame descriptor queue between front and back of the decoder.
// Depends on crsfdec_pkg for the descriptor type and depth.
module crsfdec_queue import crsfdec_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push_valid,
    input  t_desc i_push_desc,
    output logic  o_push_ready,
    output logic  o_pop_valid,
    output t_desc o_pop_desc,
    input  logic  i_pop_ready
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

    t_desc            r_entry [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             push, pop;

    assign o_push_ready = (r_count != CNT_W'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_desc   = r_entry[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        if (pop)  n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        if (push && !pop) n_count = r_count + 1'b1;
        else if (pop && !push) n_count = r_count - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_entry[r_wr_ptr] <= i_push_desc;
    end

endmodule

// ----- hw/rtl/crsfdec_back.sv -----
`timescale 1ns / 1ps
// Back end: turns a frame descriptor into channel or status results.
// Unpacks 11-bit channels by shifting the payload. Depends on crsfdec_pkg.
module crsfdec_back import crsfdec_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_pop_valid,
    input  t_desc                  i_pop_desc,
    output logic                   o_pop_ready,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [CH_IDX_W-1:0]    o_channel_index,
    output logic [CH_VALUE_W-1:0]  o_channel_value,
    output t_status                o_frame_status,
    output logic                   o_last
);

    localparam logic [CH_IDX_W-1:0] CH_LAST = CH_IDX_W'(CHANNEL_COUNT - 1);

    t_back_state             r_state, n_state;
    t_status                 r_status;
    logic [PAYLOAD_BITS-1:0] r_shift;
    logic [CH_IDX_W-1:0]     r_ch;
    logic                    fire, load;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE: if (i_pop_valid) n_state = BK_EMIT;
            BK_EMIT: if (fire && o_last && !i_pop_valid) n_state = BK_IDLE;
            default: n_state = BK_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_valid         = (r_state == BK_EMIT);
        o_last          = (r_status != ST_CHANNELS_OK) || (r_ch == CH_LAST);
        fire            = o_valid && i_ready;
        o_pop_ready     = (r_state == BK_IDLE) || (fire && o_last);
        load            = o_pop_ready && i_pop_valid;
        o_frame_status  = r_status;
        o_channel_index = r_ch;
        o_channel_value = (r_status == ST_CHANNELS_OK) ? r_shift[CH_VALUE_W-1:0] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // advance to the next channel: drop the 11 bits just sent
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_status <= i_pop_desc.status;
            r_shift  <= i_pop_desc.payload;
            r_ch     <= '0;
        end else if (fire) begin
            r_shift  <= r_shift >> CH_VALUE_W;
            r_ch     <= r_ch + 1'b1;
        end
    end

endmodule

// ----- hw/rtl/crsf_frame_channel_decoder.sv -----
`timescale 1ns / 1ps
// CRSF RC-channel frame decoder. Takes one received byte per cycle on the input stream
// and stalls input only while both entries of the frame queue are full. Each frame ends
// with a CRC-8 (poly 0xD5) check; a good frame of the channel length gives 16 results,
// one per cycle while the output is ready, from the back end's payload shift register;
// any other frame within the length bounds gives one status result.
// Top level; instantiates crsfdec_front, crsfdec_queue and crsfdec_back (crsfdec_pkg).
module crsf_frame_channel_decoder import crsfdec_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [BYTE_W-1:0]      i_s_axis_tdata,   // [7:0] rx_byte
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    output logic [TDATA_OUT_W-1:0] o_m_axis_tdata,   // [3:0] channel_index,
                                                     // [14:4] channel_value, [15] zero
    output logic [STATUS_W-1:0]    o_m_axis_tuser,   // [1:0] frame_status
    output logic                   o_m_axis_tlast    // last_of_frame
);

    logic                  push_valid, push_ready, pop_valid, pop_ready;
    t_desc                 push_desc, pop_desc;
    logic [CH_IDX_W-1:0]   ch_index;
    logic [CH_VALUE_W-1:0] ch_value;
    t_status               frame_status;

    crsfdec_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_byte_valid (i_s_axis_tvalid),
        .i_byte       (i_s_axis_tdata),
        .o_byte_ready (o_s_axis_tready),
        .o_push_valid (push_valid),
        .o_push_desc  (push_desc),
        .i_push_ready (push_ready)
    );

    crsfdec_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .i_push_desc  (push_desc),
        .o_push_ready (push_ready),
        .o_pop_valid  (pop_valid),
        .o_pop_desc   (pop_desc),
        .i_pop_ready  (pop_ready)
    );

    crsfdec_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_pop_valid     (pop_valid),
        .i_pop_desc      (pop_desc),
        .o_pop_ready     (pop_ready),
        .o_valid         (o_m_axis_tvalid),
        .i_ready         (i_m_axis_tready),
        .o_channel_index (ch_index),
        .o_channel_value (ch_value),
        .o_frame_status  (frame_status),
        .o_last          (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {{(TDATA_OUT_W - CH_IDX_W - CH_VALUE_W){1'b0}}, ch_value, ch_index};
    assign o_m_axis_tuser = frame_status;

endmodule

// ----- hw/rtl/crsfdec_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for crsf_frame_channel_decoder, attached by bind.
// Depends on crsfdec_pkg and the top level's port names.
module crsfdec_checker import crsfdec_pkg::*; (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   o_m_axis_tvalid,
    input logic                   i_m_axis_tready,
    input logic [TDATA_OUT_W-1:0] o_m_axis_tdata,
    input logic [STATUS_W-1:0]    o_m_axis_tuser,
    input logic                   o_m_axis_tlast
);

    localparam logic [CH_IDX_W-1:0] CH_LAST = CH_IDX_W'(CHANNEL_COUNT - 1);

    a_reset_clears_output: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid right after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)
            && $stable(o_m_axis_tlast))
        else $error("stalled result changed");

    a_status_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser != ST_CHANNELS_OK |->
            o_m_axis_tlast && o_m_axis_tdata == '0)
        else $error("status result not a lone zero result");

    a_channel_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && i_m_axis_tready && !o_m_axis_tlast |=>
            o_m_axis_tvalid && o_m_axis_tuser == ST_CHANNELS_OK &&
            o_m_axis_tdata[CH_IDX_W-1:0] == $past(o_m_axis_tdata[CH_IDX_W-1:0]) + 1'b1)
        else $error("channel burst broken");

    a_burst_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser == ST_CHANNELS_OK && o_m_axis_tlast |->
            o_m_axis_tdata[CH_IDX_W-1:0] == CH_LAST)
        else $error("channel burst ended on wrong index");

endmodule

bind crsf_frame_channel_decoder crsfdec_checker u_checker (.*);
